FILE: rtl/gnc_pkg.sv
// Shared constants, types and the cosine weight ROM of the 2-D gradient noise core.
// No dependencies; imported by the core and the testbench.
package gnc_pkg;

   localparam int COL_BITS   = 6;
   localparam int ROW_BITS   = 6;
   localparam int ADDR_BITS  = COL_BITS + ROW_BITS;
   localparam int TABLE_DEPTH = 1 << ADDR_BITS;
   localparam int FRAC_BITS  = 10;
   localparam int GRAD_BITS  = 15;
   localparam int ENTRY_BITS = 2 * GRAD_BITS;
   localparam int COORD_BITS = 18;
   localparam int DELTA_BITS = 12;
   localparam int DOT_BITS   = 28;
   localparam int WEIGHT_BITS = 15;
   localparam int BLEND_BITS = 44;
   localparam int ACC_BITS   = 60;
   localparam int ROUND_SHIFT = 28 + FRAC_BITS;

   localparam logic [6:0] GRID_MAX = 7'd64;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = 15'd16384;

   localparam logic CMD_QUERY = 1'b0;
   localparam logic CMD_LOAD  = 1'b1;

   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   // (1 - cos(pi * mu)) / 2 in Q1.14, mu in steps of 1/32 over [0, 2]
   localparam logic [WEIGHT_BITS-1:0] COS_ROM [0:64] = '{
      15'd0, 15'd39, 15'd157, 15'd353, 15'd624, 15'd967, 15'd1381, 15'd1859,
      15'd2399, 15'd2995, 15'd3641, 15'd4330, 15'd5057, 15'd5814, 15'd6594,
      15'd7389, 15'd8192, 15'd8995, 15'd9790, 15'd10570, 15'd11327, 15'd12054,
      15'd12743, 15'd13389, 15'd13985, 15'd14525, 15'd15003, 15'd15417,
      15'd15760, 15'd16031, 15'd16227, 15'd16345, 15'd16384,
      15'd16345, 15'd16227, 15'd16031, 15'd15760, 15'd15417, 15'd15003,
      15'd14525, 15'd13985, 15'd13389, 15'd12743, 15'd12054, 15'd11327,
      15'd10570, 15'd9790, 15'd8995, 15'd8192, 15'd7389, 15'd6594, 15'd5814,
      15'd5057, 15'd4330, 15'd3641, 15'd2995, 15'd2399, 15'd1859, 15'd1381,
      15'd967, 15'd624, 15'd353, 15'd157, 15'd39, 15'd0
   };

   typedef logic signed [DOT_BITS-1:0] dot_type;

endpackage

FILE: rtl/gnc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gnc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: rtl/gradient_noise_2d_cosine_core.sv
// Top level of the 2-D gradient noise core: cell lookup, gradient table, blend pipeline.
// Depends on gnc_pkg and gnc_ram.
//
// One item per cycle unless the result register is full and not taken. Cell and
// address calculation run in the accept cycle. The stages after it are: gradient table
// read with corner dot products and cosine weights, x blend, y blend, then rounding and
// saturation. The whole pipeline stalls as one
// when the result register is full and not taken. Loads write the gradient
// table at acceptance, so a query right behind a load already sees the new
// entry. The table is held in four copies, one per cell corner, each written by
// every load and read at its own corner address. Table entries read before
// being loaded give undefined noise values; there is no clearing pass.
module gradient_noise_2d_cosine_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_cmd,
   input  logic signed [gnc_pkg::COORD_BITS-1:0] req_coord_x,
   input  logic signed [gnc_pkg::COORD_BITS-1:0] req_coord_y,
   input  logic [gnc_pkg::COL_BITS-1:0]         req_load_col,
   input  logic [gnc_pkg::ROW_BITS-1:0]         req_load_row,
   input  logic signed [15:0]                   req_grad_x,
   input  logic signed [15:0]                   req_grad_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [15:0]                   rsp_noise_value,
   output logic                                 rsp_in_grid,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [2:0]                           paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import gnc_pkg::*;

   // ---------------- configuration ----------------
   logic [6:0] grid_width_ff, grid_height_ff;
   logic       cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= 7'd0;
         grid_height_ff <= 7'd0;
      end else if (cfg_write) begin
         if (paddr[2] == REG_GRID_WIDTH) grid_width_ff <= pwdata[6:0];
         else                            grid_height_ff <= pwdata[6:0];
      end
   end

   assign prdata = (paddr[2] == REG_GRID_HEIGHT) ? {25'd0, grid_height_ff}
                                                 : {25'd0, grid_width_ff};

   // ---------------- pipeline control ----------------
   logic advance, accept;
   logic out_valid_ff;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   // ---------------- stage 0: cell, range and addresses ----------------
   logic [6:0]            w_eff, h_eff;
   logic [COORD_BITS-1:0] mag_x, mag_y;
   logic [7:0]            q_x, q_y;
   logic                  ok_x, ok_y, grid_ok;
   logic [COL_BITS-1:0]   cx;
   logic [ROW_BITS-1:0]   cy;
   logic [COORD_BITS-1:0] dx_full, dy_full;
   logic [ADDR_BITS-1:0]  a00, a10, a01, a11, wr_addr;
   logic [ENTRY_BITS-1:0] wr_data;
   logic signed [GRAD_BITS-1:0] sat_gx, sat_gy;

   function automatic logic signed [GRAD_BITS-1:0] clamp_grad(input logic signed [15:0] v);
      logic signed [GRAD_BITS-1:0] r;
      if (v > 16'sd16383)       r = 15'sd16383;
      else if (v < -16'sd16384) r = {1'b1, {(GRAD_BITS-1){1'b0}}};
      else                      r = v[GRAD_BITS-1:0];
      return r;
   endfunction

   always_comb begin
      w_eff = (grid_width_ff  > GRID_MAX) ? GRID_MAX : grid_width_ff;
      h_eff = (grid_height_ff > GRID_MAX) ? GRID_MAX : grid_height_ff;
      mag_x = req_coord_x[COORD_BITS-1] ? COORD_BITS'(-req_coord_x) : req_coord_x;
      mag_y = req_coord_y[COORD_BITS-1] ? COORD_BITS'(-req_coord_y) : req_coord_y;
      q_x   = mag_x[COORD_BITS-1:FRAC_BITS];
      q_y   = mag_y[COORD_BITS-1:FRAC_BITS];
      // a negative point in (-1, 0) truncates to cell 0
      ok_x  = !(req_coord_x[COORD_BITS-1] && q_x != 8'd0) && ({1'b0, q_x[6:0]} < {1'b0, w_eff})
              && !q_x[7];
      ok_y  = !(req_coord_y[COORD_BITS-1] && q_y != 8'd0) && ({1'b0, q_y[6:0]} < {1'b0, h_eff})
              && !q_y[7];
      grid_ok = (req_cmd == CMD_QUERY) && (w_eff >= 7'd2) && (h_eff >= 7'd2) && ok_x && ok_y;
      // last column or row: step back one cell
      cx = (q_x[6:0] == w_eff - 7'd1) ? COL_BITS'(q_x - 8'd1) : q_x[COL_BITS-1:0];
      cy = (q_y[6:0] == h_eff - 7'd1) ? ROW_BITS'(q_y - 8'd1) : q_y[ROW_BITS-1:0];
      dx_full = req_coord_x - {2'b00, cx, {FRAC_BITS{1'b0}}};
      dy_full = req_coord_y - {2'b00, cy, {FRAC_BITS{1'b0}}};
      a00 = {cy, cx};
      a10 = {cy, COL_BITS'(cx + 1'b1)};
      a01 = {ROW_BITS'(cy + 1'b1), cx};
      a11 = {ROW_BITS'(cy + 1'b1), COL_BITS'(cx + 1'b1)};
      sat_gx  = clamp_grad(req_grad_x);
      sat_gy  = clamp_grad(req_grad_y);
      wr_addr = {req_load_row, req_load_col};
      wr_data = {sat_gx, sat_gy};
   end

   logic load_en;
   assign load_en = accept && (req_cmd == CMD_LOAD);

   logic [ENTRY_BITS-1:0] e00, e10, e01, e11;

   gnc_ram #(.WIDTH(ENTRY_BITS), .DEPTH(TABLE_DEPTH)) u_ram00 (
      .clock(clock), .wr_en(load_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_en(advance), .rd_addr(a00), .rd_data(e00));
   gnc_ram #(.WIDTH(ENTRY_BITS), .DEPTH(TABLE_DEPTH)) u_ram10 (
      .clock(clock), .wr_en(load_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_en(advance), .rd_addr(a10), .rd_data(e10));
   gnc_ram #(.WIDTH(ENTRY_BITS), .DEPTH(TABLE_DEPTH)) u_ram01 (
      .clock(clock), .wr_en(load_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_en(advance), .rd_addr(a01), .rd_data(e01));
   gnc_ram #(.WIDTH(ENTRY_BITS), .DEPTH(TABLE_DEPTH)) u_ram11 (
      .clock(clock), .wr_en(load_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_en(advance), .rd_addr(a11), .rd_data(e11));

   // ---------------- stage 1 registers ----------------
   logic s1_valid_ff, s1_grid_ff;
   logic signed [DELTA_BITS-1:0] s1_dx0_ff, s1_dy0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_grid_ff <= grid_ok;
         s1_dx0_ff  <= dx_full[DELTA_BITS-1:0];
         s1_dy0_ff  <= dy_full[DELTA_BITS-1:0];
      end
   end

   // ---------------- stage 1: dot products and weights ----------------
   function automatic dot_type corner_dot(input logic [ENTRY_BITS-1:0] e,
                                          input logic signed [DELTA_BITS-1:0] dx,
                                          input logic signed [DELTA_BITS-1:0] dy);
      logic signed [GRAD_BITS-1:0] gx, gy;
      dot_type px, py;
      gx = e[ENTRY_BITS-1:GRAD_BITS];
      gy = e[GRAD_BITS-1:0];
      px = gx * dx;
      py = gy * dy;
      return px + py;
   endfunction

   function automatic logic [WEIGHT_BITS-1:0] cos_weight(input logic signed [DELTA_BITS-1:0] mu);
      logic [DELTA_BITS-1:0] a;
      logic [5:0]  idx;
      logic [4:0]  f;
      logic [19:0] acc;
      a   = mu[DELTA_BITS-1] ? DELTA_BITS'(-mu) : mu;
      idx = a[10:5];
      f   = a[4:0];
      acc = 20'(COS_ROM[idx]) * 20'(6'd32 - {1'b0, f})
            + 20'(COS_ROM[7'(idx) + 7'd1]) * 20'(f) + 20'd16;
      return acc[19:5];
   endfunction

   logic signed [DELTA_BITS-1:0] dx1, dy1;
   dot_type n00, n10, n01, n11;
   logic [WEIGHT_BITS-1:0] wx, wy;

   always_comb begin
      dx1 = s1_dx0_ff - DELTA_BITS'(1 << FRAC_BITS);
      dy1 = s1_dy0_ff - DELTA_BITS'(1 << FRAC_BITS);
      n00 = corner_dot(e00, s1_dx0_ff, s1_dy0_ff);
      n10 = corner_dot(e10, dx1, s1_dy0_ff);
      n01 = corner_dot(e01, s1_dx0_ff, dy1);
      n11 = corner_dot(e11, dx1, dy1);
      wx  = cos_weight(s1_dx0_ff);
      wy  = cos_weight(s1_dy0_ff);
   end

   logic s2_valid_ff, s2_grid_ff;
   dot_type s2_n00_ff, s2_n10_ff, s2_n01_ff, s2_n11_ff;
   logic [WEIGHT_BITS-1:0] s2_wx_ff, s2_wy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_grid_ff <= s1_grid_ff;
         s2_n00_ff  <= n00;
         s2_n10_ff  <= n10;
         s2_n01_ff  <= n01;
         s2_n11_ff  <= n11;
         s2_wx_ff   <= wx;
         s2_wy_ff   <= wy;
      end
   end

   // ---------------- stage 2: blend along x ----------------
   logic signed [WEIGHT_BITS:0] wsx, wcx;
   logic signed [BLEND_BITS-1:0] ix0, ix1;

   always_comb begin
      wsx = $signed({1'b0, s2_wx_ff});
      wcx = $signed({1'b0, WEIGHT_BITS'(WEIGHT_ONE - s2_wx_ff)});
      ix0 = BLEND_BITS'(s2_n00_ff) * BLEND_BITS'(wcx) + BLEND_BITS'(s2_n10_ff) * BLEND_BITS'(wsx);
      ix1 = BLEND_BITS'(s2_n01_ff) * BLEND_BITS'(wcx) + BLEND_BITS'(s2_n11_ff) * BLEND_BITS'(wsx);
   end

   logic s3_valid_ff, s3_grid_ff;
   logic signed [BLEND_BITS-1:0] s3_ix0_ff, s3_ix1_ff;
   logic [WEIGHT_BITS-1:0] s3_wy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_grid_ff <= s2_grid_ff;
         s3_ix0_ff  <= ix0;
         s3_ix1_ff  <= ix1;
         s3_wy_ff   <= s2_wy_ff;
      end
   end

   // ---------------- stage 3: blend along y ----------------
   logic signed [WEIGHT_BITS:0] wsy, wcy;
   logic signed [ACC_BITS-1:0] v_in;

   always_comb begin
      wsy  = $signed({1'b0, s3_wy_ff});
      wcy  = $signed({1'b0, WEIGHT_BITS'(WEIGHT_ONE - s3_wy_ff)});
      v_in = ACC_BITS'(s3_ix0_ff) * ACC_BITS'(wcy) + ACC_BITS'(s3_ix1_ff) * ACC_BITS'(wsy);
   end

   logic s4_valid_ff, s4_grid_ff;
   logic signed [ACC_BITS-1:0] s4_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_grid_ff <= s3_grid_ff;
         s4_v_ff    <= v_in;
      end
   end

   // ---------------- stage 4: round half up and saturate ----------------
   logic signed [ACC_BITS-1:0] rounded;
   logic signed [ACC_BITS-ROUND_SHIFT-1:0] shifted;
   logic signed [15:0] noise_in;

   always_comb begin
      rounded = s4_v_ff + (ACC_BITS'(1) <<< (ROUND_SHIFT - 1));
      shifted = rounded[ACC_BITS-1:ROUND_SHIFT];
      if (!s4_grid_ff)                                      noise_in = 16'sd0;
      else if (shifted > (ACC_BITS-ROUND_SHIFT)'(32767))    noise_in = 16'sd32767;
      else if (shifted < -(ACC_BITS-ROUND_SHIFT)'(32768))   noise_in = -16'sd32768;
      else                                                  noise_in = shifted[15:0];
   end

   logic signed [15:0] out_noise_ff;
   logic               out_grid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_noise_ff <= noise_in;
         out_grid_ff  <= s4_grid_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_noise_value = out_noise_ff;
   assign rsp_in_grid     = out_grid_ff;

endmodule

FILE: bench/testbench.sv
// Testbench for gradient_noise_2d_cosine_core: gradient table loads and noise queries,
// checked item by item against a built-in predictor. Depends on gnc_pkg and the core RTL.
`timescale 1ns / 100ps

module testbench;
   import gnc_pkg::*;

   localparam int LATENCY = 5;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [2:0] ADDR_WIDTH_REG  = 3'd0;
   localparam logic [2:0] ADDR_HEIGHT_REG = 3'd4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_cmd = CMD_QUERY;
   logic signed [COORD_BITS-1:0] req_coord_x = '0;
   logic signed [COORD_BITS-1:0] req_coord_y = '0;
   logic [COL_BITS-1:0] req_load_col = '0;
   logic [ROW_BITS-1:0] req_load_row = '0;
   logic signed [15:0] req_grad_x = '0;
   logic signed [15:0] req_grad_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_noise_value;
   logic rsp_in_grid;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   gradient_noise_2d_cosine_core uut (.*);

   typedef struct {
      logic signed [15:0] noise_value;
      logic               in_grid;
   } noise_result_type;

   class noise_scoreboard_type;
      logic signed [GRAD_BITS-1:0] grad_x_tbl [TABLE_DEPTH];
      logic signed [GRAD_BITS-1:0] grad_y_tbl [TABLE_DEPTH];
      int unsigned width_cfg, height_cfg;
      noise_result_type pending_results [$];
      int errors;

      function void report(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endfunction

      function longint sat_grad(longint v);
         if (v > 16383) return 16383;
         if (v < -16384) return -16384;
         return v;
      endfunction

      function longint cell_of(longint v);
         return (v >= 0) ? (v >>> FRAC_BITS) : -((-v) >>> FRAC_BITS);
      endfunction

      function longint blend_weight(longint mu);
         longint a, idx, f;
         a = (mu < 0) ? -mu : mu;
         if (a > 2047) a = 2047;
         idx = a >> 5;
         f = a & 31;
         return (longint'(COS_ROM[idx]) * (32 - f) + longint'(COS_ROM[idx + 1]) * f + 16) >>> 5;
      endfunction

      function longint dot_at(longint col, longint row, longint dx, longint dy);
         int i;
         i = row * 64 + col;
         return longint'(grad_x_tbl[i]) * dx + longint'(grad_y_tbl[i]) * dy;
      endfunction

      // predict one result from one accepted item
      function void note_item(logic cmd, logic signed [17:0] x, logic signed [17:0] y,
                              logic [5:0] col, logic [5:0] row,
                              logic signed [15:0] gx, logic signed [15:0] gy);
         noise_result_type r;
         longint w, h, cx, cy, dx0, dy0, dx1, dy1, wx, wy, ix0, ix1, v, t;
         r.noise_value = 0;
         r.in_grid = 0;
         if (cmd == CMD_LOAD) begin
            grad_x_tbl[row * 64 + col] = sat_grad(gx);
            grad_y_tbl[row * 64 + col] = sat_grad(gy);
         end else begin
            w = (width_cfg > 64) ? 64 : width_cfg;
            h = (height_cfg > 64) ? 64 : height_cfg;
            cx = cell_of(x);
            cy = cell_of(y);
            if (w >= 2 && h >= 2 && cx >= 0 && cy >= 0 && cx <= w - 1 && cy <= h - 1) begin
               if (cx == w - 1) cx--;
               if (cy == h - 1) cy--;
               dx0 = x - cx * 1024;
               dy0 = y - cy * 1024;
               dx1 = dx0 - 1024;
               dy1 = dy0 - 1024;
               wx = blend_weight(dx0);
               wy = blend_weight(dy0);
               ix0 = dot_at(cx, cy, dx0, dy0) * (16384 - wx) + dot_at(cx + 1, cy, dx1, dy0) * wx;
               ix1 = dot_at(cx, cy + 1, dx0, dy1) * (16384 - wx)
                     + dot_at(cx + 1, cy + 1, dx1, dy1) * wx;
               v = ix0 * (16384 - wy) + ix1 * wy;
               t = v + (64'sd1 <<< (ROUND_SHIFT - 1));
               v = t >>> ROUND_SHIFT;
               if (v > 32767) v = 32767;
               if (v < -32768) v = -32768;
               r.noise_value = v;
               r.in_grid = 1;
            end
         end
         pending_results.push_back(r);
      endfunction

      function void check_result(logic signed [15:0] nv, logic ig);
         noise_result_type e;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result noise=%0d in_grid=%0b", nv, ig));
            return;
         end
         e = pending_results.pop_front();
         if (nv !== e.noise_value)
            report($sformatf("noise_value got %0d want %0d", nv, e.noise_value));
         if (ig !== e.in_grid)
            report($sformatf("in_grid got %0b want %0b", ig, e.in_grid));
      endfunction
   endclass

   noise_scoreboard_type sb = new();
   int unsigned cycle_count = 0;
   int idle_pct = 32;
   bit hold_results = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side: sample at the rising edge, change ready at the falling edge
   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_noise_value, rsp_in_grid);

   always @(negedge clock)
      rsp_ready <= !hold_results && ($urandom_range(99) >= idle_pct);

   task automatic write_reg(logic [2:0] addr, int unsigned value);
      @(negedge clock);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= value;
      @(negedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (addr == ADDR_WIDTH_REG) sb.width_cfg = value & 7'h7f;
      else sb.height_cfg = value & 7'h7f;
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   // valid stays high into the next item unless an idle cycle or a drain drops it
   task automatic send_item(logic cmd, logic signed [17:0] x, logic signed [17:0] y,
                            logic [5:0] col, logic [5:0] row,
                            logic signed [15:0] gx, logic signed [15:0] gy);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1; req_cmd <= cmd; req_coord_x <= x; req_coord_y <= y;
      req_load_col <= col; req_load_row <= row; req_grad_x <= gx; req_grad_y <= gy;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_item(cmd, x, y, col, row, gx, gy);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (sb.pending_results.size() != 0) @(negedge clock);
      repeat (LATENCY + 3) @(negedge clock);
   endtask

   task automatic load_grad(int col, int row, logic signed [15:0] gx, logic signed [15:0] gy);
      send_item(CMD_LOAD, $urandom, $urandom, col, row, gx, gy);
   endtask

   function automatic logic signed [15:0] rand_grad();
      return $signed(16'($urandom_range(32768))) - 16'sd16384;
   endfunction

   // random query; mostly cells over the loaded area, sometimes far outside any grid
   task automatic random_query(int span);
      logic signed [17:0] x, y, far;
      if ($urandom_range(9) < 8) begin
         x = $urandom_range(span * 1024 - 1);
         y = $urandom_range(span * 1024 - 1);
         if ($urandom_range(9) == 0) x = -$signed(18'($urandom_range(1023)));
         if ($urandom_range(9) == 0) y = -$signed(18'($urandom_range(1023)));
      end else begin
         if ($urandom_range(1) == 0) far = 18'($urandom_range(131071, 65536));
         else far = -$signed(18'($urandom_range(131072, 1025)));
         if ($urandom_range(1) == 0) begin
            x = far; y = $urandom;
         end else begin
            x = $urandom; y = far;
         end
      end
      send_item(CMD_QUERY, x, y, $urandom, $urandom, $urandom, $urandom);
   endtask

   initial begin
      int r, c, n;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // query with reset grid gives zero
      send_item(CMD_QUERY, 18'sd1500, 18'sd1500, 0, 0, 0, 0);
      // fill the low 16 x 16 corner and the top 2 x 2 corner; queries stay on them
      idle_pct = 0;
      for (r = 0; r < 16; r++)
         for (c = 0; c < 16; c++)
            load_grad(c, r, rand_grad(), rand_grad());
      for (r = 62; r < 64; r++)
         for (c = 62; c < 64; c++)
            load_grad(c, r, rand_grad(), rand_grad());
      idle_pct = 32;
      // extreme gradients, including saturation of +1.0
      load_grad(0, 0, 16'sd16384, -16'sd16384);
      load_grad(1, 0, -16'sd16384, 16'sd16384);
      load_grad(0, 1, 16'sd16384, 16'sd16384);
      load_grad(1, 1, -16'sd16384, -16'sd16384);
      drain();
      write_reg(ADDR_WIDTH_REG, 1);
      write_reg(ADDR_HEIGHT_REG, 64);
      send_item(CMD_QUERY, 18'sd512, 18'sd512, 0, 0, 0, 0);
      drain();
      write_reg(ADDR_WIDTH_REG, 127);
      write_reg(ADDR_HEIGHT_REG, 127);
      send_item(CMD_QUERY, 18'sd512, 18'sd512, 0, 0, 0, 0);
      send_item(CMD_QUERY, 18'sd0, 18'sd0, 0, 0, 0, 0);
      send_item(CMD_QUERY, -18'sd300, -18'sd1023, 0, 0, 0, 0);
      send_item(CMD_QUERY, -18'sd1024, 18'sd10, 0, 0, 0, 0);
      send_item(CMD_QUERY, 18'sd131071, 18'sd131071, 0, 0, 0, 0);
      send_item(CMD_QUERY, -18'sd131072, -18'sd131072, 0, 0, 0, 0);
      send_item(CMD_QUERY, 18'sd65535, 18'sd65535, 0, 0, 0, 0);
      send_item(CMD_QUERY, 18'sd64512, 18'sd64600, 0, 0, 0, 0);
      send_item(CMD_QUERY, 18'sd1023, 18'sd1023, 0, 0, 0, 0);
      send_item(CMD_QUERY, 18'sd1536, 18'sd15000, 0, 0, 0, 0);
      send_item(CMD_QUERY, 18'sd65536, 18'sd0, 0, 0, 0, 0);
      drain();

      // random phases over several grid sizes
      for (n = 0; n < 5; n++) begin
         case (n)
            0: begin write_reg(ADDR_WIDTH_REG, 16); write_reg(ADDR_HEIGHT_REG, 16); end
            1: begin write_reg(ADDR_WIDTH_REG, 2); write_reg(ADDR_HEIGHT_REG, 2); end
            2: begin write_reg(ADDR_WIDTH_REG, $urandom_range(3, 16));
                     write_reg(ADDR_HEIGHT_REG, $urandom_range(3, 16)); end
            3: begin write_reg(ADDR_WIDTH_REG, 0); write_reg(ADDR_HEIGHT_REG, 64); end
            default: begin write_reg(ADDR_WIDTH_REG, 100); write_reg(ADDR_HEIGHT_REG, 5); end
         endcase
         idle_pct = (n == 1) ? 0 : 32;
         for (c = 0; c < 115; c++) begin
            if (n == 2 && c == 40) begin
               // stall results long enough to back the pipeline up
               fork
                  begin hold_results = 1; repeat (60) @(posedge clock); hold_results = 0; end
               join_none
            end
            if ($urandom_range(9) == 0)
               load_grad($urandom_range(63), $urandom_range(63), rand_grad(), rand_grad());
            else if (n == 1)
               random_query(3);
            else if (n == 4)
               random_query(15);
            else
               random_query(17);
         end
         // hold off sending until every result is back
         drain();
      end
      if (sb.errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

FILE: gradient_noise_2d_cosine_core.f
rtl/gnc_pkg.sv
rtl/gnc_ram.sv
rtl/gradient_noise_2d_cosine_core.sv
bench/testbench.sv
